>>> rtl/lift_ramp_p_controller_unit_macros.svh
// Assertion macros for the lift ramp controller; only lrpc_ctrl includes them.
`ifndef LIFT_RAMP_P_CONTROLLER_UNIT_MACROS_SVH
`define LIFT_RAMP_P_CONTROLLER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LRPC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lrpc: same-cycle property violated");

// The consequent must hold in the cycle after the antecedent.
`define LRPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lrpc: next-cycle property violated");

`endif

>>> rtl/lrpc_pkg.sv
package lrpc_pkg;

    // Fixed field widths.
    localparam int POSITION_WIDTH = 16;
    localparam int GAIN_FRAC_BITS = 12;
    localparam int KP_W           = 16;
    localparam int PWM_W          = 8;
    localparam int STEP_W         = 10;
    localparam int CODE_W         = 2;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = (POSITION_WIDTH > KP_W) ? POSITION_WIDTH : KP_W;

    // Operation codes.
    localparam logic [CODE_W-1:0] OP_TICK   = 2'd0;
    localparam logic [CODE_W-1:0] OP_MANUAL = 2'd1;
    localparam logic [CODE_W-1:0] OP_AUTO   = 2'd2;

    // Lift actions, also used for the commanded direction.
    localparam logic [CODE_W-1:0] ACT_STOP = 2'd0;
    localparam logic [CODE_W-1:0] ACT_UP   = 2'd1;
    localparam logic [CODE_W-1:0] ACT_DOWN = 2'd2;

    // Motor bridge modes.
    localparam logic [CODE_W-1:0] DRV_RELEASE  = 2'd0;
    localparam logic [CODE_W-1:0] DRV_FORWARD  = 2'd1;
    localparam logic [CODE_W-1:0] DRV_BACKWARD = 2'd2;

    // Configuration register indices.
    localparam logic [CFG_IDX_W-1:0] CFG_KP_GAIN         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MANUAL_UP_PWM   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MANUAL_DOWN_PWM = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER_LIMIT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER_LIMIT     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_STEP       = 3'd5;

    // Reset values.
    localparam logic [KP_W-1:0]                  KP_GAIN_RESET         = 16'd819;
    localparam logic [PWM_W-1:0]                 MANUAL_UP_PWM_RESET   = 8'd90;
    localparam logic [PWM_W-1:0]                 MANUAL_DOWN_PWM_RESET = 8'd70;
    localparam logic signed [POSITION_WIDTH-1:0] UPPER_LIMIT_RESET     = POSITION_WIDTH'(1500);
    localparam logic signed [POSITION_WIDTH-1:0] LOWER_LIMIT_RESET     = '0;
    localparam logic [STEP_W-1:0]                RAMP_STEP_RESET       = 10'd20;
    localparam logic [PWM_W-1:0]                 PWM_RESET             = 8'd70;

    // Largest duty the bridge accepts.
    localparam logic [PWM_W-1:0] DUTY_MAX = 8'd255;

    typedef struct packed {
        logic [KP_W-1:0]                  kp_gain;
        logic [PWM_W-1:0]                 manual_up_pwm;
        logic [PWM_W-1:0]                 manual_down_pwm;
        logic signed [POSITION_WIDTH-1:0] upper_limit;
        logic signed [POSITION_WIDTH-1:0] lower_limit;
        logic [STEP_W-1:0]                ramp_step;
    } lrpc_cfg_t;

    typedef struct packed {
        logic [CODE_W-1:0]                opcode;
        logic [CODE_W-1:0]                direction;
        logic signed [POSITION_WIDTH-1:0] lift_position;
        logic                             interlock_up;
        logic                             interlock_down;
    } lrpc_item_t;

    typedef struct packed {
        logic [CODE_W-1:0] drive_mode;
        logic [PWM_W-1:0]  pwm_duty;
        logic [CODE_W-1:0] current_action;
        logic              manual_mode;
        logic              command_ignored;
    } lrpc_result_t;

endpackage

>>> rtl/lrpc_cfg_regs.sv
module lrpc_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic [lrpc_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [lrpc_pkg::CFG_DATA_W-1:0] wr_data,
    output lrpc_pkg::lrpc_cfg_t            cfg
);
    import lrpc_pkg::*;

    lrpc_cfg_t cfg_reg;
    lrpc_cfg_t cfg_next;

    // Decode the write beat onto the addressed register; unknown indices are dropped.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                CFG_KP_GAIN:         cfg_next.kp_gain         = wr_data[KP_W-1:0];
                CFG_MANUAL_UP_PWM:   cfg_next.manual_up_pwm   = wr_data[PWM_W-1:0];
                CFG_MANUAL_DOWN_PWM: cfg_next.manual_down_pwm = wr_data[PWM_W-1:0];
                CFG_UPPER_LIMIT:     cfg_next.upper_limit     = wr_data[POSITION_WIDTH-1:0];
                CFG_LOWER_LIMIT:     cfg_next.lower_limit     = wr_data[POSITION_WIDTH-1:0];
                CFG_RAMP_STEP:       cfg_next.ramp_step       = wr_data[STEP_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kp_gain         <= KP_GAIN_RESET;
            cfg_reg.manual_up_pwm   <= MANUAL_UP_PWM_RESET;
            cfg_reg.manual_down_pwm <= MANUAL_DOWN_PWM_RESET;
            cfg_reg.upper_limit     <= UPPER_LIMIT_RESET;
            cfg_reg.lower_limit     <= LOWER_LIMIT_RESET;
            cfg_reg.ramp_step       <= RAMP_STEP_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/lrpc_duty.sv
module lrpc_duty (
    input  logic [lrpc_pkg::KP_W-1:0]           kp_gain,
    input  logic [lrpc_pkg::POSITION_WIDTH-1:0] err_mag,
    output logic [lrpc_pkg::PWM_W-1:0]          duty
);
    import lrpc_pkg::*;

    localparam int PROD_W = KP_W + POSITION_WIDTH;

    logic [PROD_W-1:0] product;
    logic [PROD_W-1:0] scaled;

    // Gain times error magnitude, dropping the fractional bits of the gain.
    assign product = PROD_W'(kp_gain) * PROD_W'(err_mag);
    assign scaled  = product >> GAIN_FRAC_BITS;

    // Clamp to the largest duty instead of wrapping.
    assign duty = (scaled > PROD_W'(DUTY_MAX)) ? DUTY_MAX : scaled[PWM_W-1:0];

endmodule

>>> rtl/lrpc_ctrl.sv
`include "lift_ramp_p_controller_unit_macros.svh"

module lrpc_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   fire,
    input  lrpc_pkg::lrpc_item_t   item,
    input  lrpc_pkg::lrpc_cfg_t    cfg,
    output lrpc_pkg::lrpc_result_t result
);
    import lrpc_pkg::*;

    localparam int SUM_W = POSITION_WIDTH + 2;
    localparam int ERR_W = POSITION_WIDTH + 1;

    localparam logic signed [SUM_W-1:0] POS_MAX_W = $signed({3'b000, {(POSITION_WIDTH-1){1'b1}}});
    localparam logic signed [SUM_W-1:0] POS_MIN_W = $signed({3'b111, {(POSITION_WIDTH-1){1'b0}}});

    logic [CODE_W-1:0]                action_reg, action_next;
    logic                             manual_reg, manual_next;
    logic signed [POSITION_WIDTH-1:0] ref_reg, ref_next;
    logic [CODE_W-1:0]                drive_reg, drive_next;
    logic [PWM_W-1:0]                 pwm_reg, pwm_next;
    logic                             ignored;

    logic [CODE_W-1:0]                dir_norm;
    logic signed [SUM_W-1:0]          ref_wide;
    logic signed [SUM_W-1:0]          step_wide;
    logic signed [SUM_W-1:0]          ref_sum;
    logic signed [POSITION_WIDTH-1:0] ref_ramp;
    logic signed [ERR_W-1:0]          err;
    logic signed [ERR_W-1:0]          err_neg;
    logic [POSITION_WIDTH-1:0]        err_mag;
    logic [PWM_W-1:0]                 duty;
    logic                             past_upper;
    logic                             past_lower;

    // A direction code outside the known set means stop.
    always_comb
    begin
        case (item.direction)
            ACT_UP:   dir_norm = ACT_UP;
            ACT_DOWN: dir_norm = ACT_DOWN;
            default:  dir_norm = ACT_STOP;
        endcase
    end

    // Ramp the reference one step in the move direction, saturating at the position range.
    always_comb
    begin
        ref_wide  = {{2{ref_reg[POSITION_WIDTH-1]}}, ref_reg};
        step_wide = $signed({{(SUM_W-STEP_W){1'b0}}, cfg.ramp_step});
        if (action_reg == ACT_DOWN)
        begin
            ref_sum = ref_wide - step_wide;
        end
        else
        begin
            ref_sum = ref_wide + step_wide;
        end
        if (ref_sum > POS_MAX_W)
        begin
            ref_ramp = POS_MAX_W[POSITION_WIDTH-1:0];
        end
        else if (ref_sum < POS_MIN_W)
        begin
            ref_ramp = POS_MIN_W[POSITION_WIDTH-1:0];
        end
        else
        begin
            ref_ramp = ref_sum[POSITION_WIDTH-1:0];
        end
    end

    // Error in the move direction; zero when the lift is already ahead of the reference.
    always_comb
    begin
        err     = {ref_ramp[POSITION_WIDTH-1], ref_ramp}
                - {item.lift_position[POSITION_WIDTH-1], item.lift_position};
        err_neg = -err;
        err_mag = '0;
        if (action_reg == ACT_UP && !err[ERR_W-1] && err != '0)
        begin
            err_mag = err[POSITION_WIDTH-1:0];
        end
        else if (action_reg == ACT_DOWN && err[ERR_W-1])
        begin
            err_mag = err_neg[POSITION_WIDTH-1:0];
        end
    end

    lrpc_duty u_duty (
        .kp_gain (cfg.kp_gain),
        .err_mag (err_mag),
        .duty    (duty)
    );

    assign past_upper = $signed(item.lift_position) > $signed(cfg.upper_limit);
    assign past_lower = $signed(item.lift_position) < $signed(cfg.lower_limit);

    // Next state for the item at the head of the pipeline.
    always_comb
    begin
        action_next = action_reg;
        manual_next = manual_reg;
        ref_next    = ref_reg;
        drive_next  = drive_reg;
        pwm_next    = pwm_reg;
        ignored     = 1'b0;
        case (item.opcode)
            OP_TICK:
            begin
                if (!manual_reg && action_reg == ACT_UP)
                begin
                    if (past_upper || item.interlock_up)
                    begin
                        action_next = ACT_STOP;
                        drive_next  = DRV_RELEASE;
                    end
                    else
                    begin
                        drive_next = DRV_FORWARD;
                        ref_next   = ref_ramp;
                        pwm_next   = duty;
                    end
                end
                else if (!manual_reg && action_reg == ACT_DOWN)
                begin
                    if (past_lower || item.interlock_down)
                    begin
                        action_next = ACT_STOP;
                        drive_next  = DRV_RELEASE;
                    end
                    else
                    begin
                        drive_next = DRV_BACKWARD;
                        ref_next   = ref_ramp;
                        pwm_next   = duty;
                    end
                end
            end
            OP_MANUAL:
            begin
                manual_next = 1'b1;
                action_next = dir_norm;
                if (dir_norm == ACT_UP)
                begin
                    drive_next = DRV_FORWARD;
                    pwm_next   = cfg.manual_up_pwm;
                end
                else if (dir_norm == ACT_DOWN)
                begin
                    drive_next = DRV_BACKWARD;
                    pwm_next   = cfg.manual_down_pwm;
                end
                else
                begin
                    drive_next = DRV_RELEASE;
                end
            end
            OP_AUTO:
            begin
                if (item.interlock_up || item.interlock_down)
                begin
                    ignored = 1'b1;
                end
                else
                begin
                    manual_next = 1'b0;
                    action_next = dir_norm;
                    ref_next    = item.lift_position;
                    if (dir_norm == ACT_STOP)
                    begin
                        drive_next = DRV_RELEASE;
                    end
                end
            end
            default:
            begin
                ignored = 1'b0;
            end
        endcase
    end

    // Controller state advances once per item beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            action_reg <= ACT_STOP;
            manual_reg <= 1'b0;
            ref_reg    <= '0;
            drive_reg  <= DRV_RELEASE;
            pwm_reg    <= PWM_RESET;
        end
        else if (fire)
        begin
            action_reg <= action_next;
            manual_reg <= manual_next;
            ref_reg    <= ref_next;
            drive_reg  <= drive_next;
            pwm_reg    <= pwm_next;
        end
    end

    // The result shows the state after the step.
    assign result.drive_mode      = drive_next;
    assign result.pwm_duty        = pwm_next;
    assign result.current_action  = action_next;
    assign result.manual_mode     = manual_next;
    assign result.command_ignored = ignored;

    `LRPC_ASSERT_NEXT(a_refused_keeps_state, clk, rst_n, fire && ignored,
        $stable(action_reg) && $stable(manual_reg) && $stable(ref_reg) && $stable(drive_reg))
    `LRPC_ASSERT_NEXT(a_idle_keeps_state, clk, rst_n, !fire,
        $stable(ref_reg) && $stable(pwm_reg) && $stable(action_reg))
    `LRPC_ASSERT_SAME(a_manual_up_drives_forward, clk, rst_n,
        manual_reg && action_reg == ACT_UP, drive_reg == DRV_FORWARD)
    `LRPC_ASSERT_SAME(a_manual_stop_releases, clk, rst_n,
        manual_reg && action_reg == ACT_STOP, drive_reg == DRV_RELEASE)

endmodule

>>> rtl/lift_ramp_p_controller_unit.sv
// Lift ramp controller: each item beat (control tick, manual command or auto command)
// yields exactly one result beat showing the bridge mode, duty and action after the step.
// An item passes through an input register and then a result register, which loads when
// it is empty or its beat is being taken; the result is held there until it is taken. One item
// is taken every cycle while the result side keeps up; the step, including the single gain
// multiply, is combinational between those registers. The configuration port is
// always ready and must only be written while no item is in flight.
module lift_ramp_p_controller_unit (
    input  logic                                       clk,
    input  logic                                       rst_n,
    // Item channel.
    input  logic                                       item_valid,
    output logic                                       item_stall,
    input  logic [lrpc_pkg::CODE_W-1:0]                opcode,
    input  logic [lrpc_pkg::CODE_W-1:0]                direction,
    input  logic signed [lrpc_pkg::POSITION_WIDTH-1:0] lift_position,
    input  logic                                       interlock_up,
    input  logic                                       interlock_down,
    // Result channel.
    output logic                                       result_valid,
    input  logic                                       result_stall,
    output logic [lrpc_pkg::CODE_W-1:0]                drive_mode,
    output logic [lrpc_pkg::PWM_W-1:0]                 pwm_duty,
    output logic [lrpc_pkg::CODE_W-1:0]                current_action,
    output logic                                       manual_mode,
    output logic                                       command_ignored,
    // Configuration write channel.
    input  logic                                       cfg_valid,
    output logic                                       cfg_ready,
    input  logic [lrpc_pkg::CFG_IDX_W-1:0]             cfg_index,
    input  logic [lrpc_pkg::CFG_DATA_W-1:0]            cfg_data
);
    import lrpc_pkg::*;

    lrpc_cfg_t    cfg;
    lrpc_item_t   item_reg;
    lrpc_result_t res_reg;
    lrpc_result_t res_step;
    logic         item_vld_reg, item_vld_next;
    logic         res_vld_reg, res_vld_next;
    logic         advance;
    logic         take_item;
    logic         fire;

    assign cfg_ready = 1'b1;

    lrpc_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // The result register can load when it is empty or its beat is being taken.
    assign advance    = !res_vld_reg || !result_stall;
    assign fire       = item_vld_reg && advance;
    assign item_stall = item_vld_reg && !advance;
    assign take_item  = item_valid && !item_stall;

    always_comb
    begin
        if (take_item)
        begin
            item_vld_next = 1'b1;
        end
        else if (advance)
        begin
            item_vld_next = 1'b0;
        end
        else
        begin
            item_vld_next = item_vld_reg;
        end

        if (fire)
        begin
            res_vld_next = 1'b1;
        end
        else if (advance)
        begin
            res_vld_next = 1'b0;
        end
        else
        begin
            res_vld_next = res_vld_reg;
        end
    end

    // Handshake state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg <= 1'b0;
            res_vld_reg  <= 1'b0;
        end
        else
        begin
            item_vld_reg <= item_vld_next;
            res_vld_reg  <= res_vld_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (take_item)
        begin
            item_reg.opcode         <= opcode;
            item_reg.direction      <= direction;
            item_reg.lift_position  <= lift_position;
            item_reg.interlock_up   <= interlock_up;
            item_reg.interlock_down <= interlock_down;
        end
        if (fire)
        begin
            res_reg <= res_step;
        end
    end

    lrpc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (item_reg),
        .cfg    (cfg),
        .result (res_step)
    );

    assign result_valid    = res_vld_reg;
    assign drive_mode      = res_reg.drive_mode;
    assign pwm_duty        = res_reg.pwm_duty;
    assign current_action  = res_reg.current_action;
    assign manual_mode     = res_reg.manual_mode;
    assign command_ignored = res_reg.command_ignored;

endmodule
